[rtl/pce_pkg.sv]
// Shared types and constants of the palette compaction engine.
// Used by every module of the block; has no dependencies.
package pce_pkg;

  localparam int MAX_COLORS = 4096;
  localparam int IDX_W      = $clog2(MAX_COLORS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int CFG_W      = 13;
  localparam int KIND_W     = 3;
  localparam int COMP_W     = 8;
  localparam int RGB_W      = 3 * COMP_W;
  localparam int STATUS_W   = 2;

  localparam int MARK_W     = 16;
  localparam int MARK_ROWS  = MAX_COLORS / MARK_W;
  localparam int ROW_W      = $clog2(MARK_ROWS);
  localparam int BIT_W      = $clog2(MARK_W);

  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);

  localparam int S_FIELDS_W = IDX_W + RGB_W;
  localparam int S_DATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
  localparam int M_FIELDS_W = IDX_W + RGB_W + CNT_W + STATUS_W;
  localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [KIND_W-1:0] {
    OP_WRITE  = 3'd0,
    OP_SCAN   = 3'd1,
    OP_FINISH = 3'd2,
    OP_REMAP  = 3'd3,
    OP_READ   = 3'd4,
    OP_START  = 3'd5,
    OP_NOP    = 3'd6
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_SKIP  = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef struct packed {
    op_e               op;
    logic              in_range;
    logic [IDX_W-1:0]  idx;
    logic [COMP_W-1:0] red;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] blue;
  } item_t;

  typedef struct packed {
    logic [IDX_W-1:0]  new_index;
    logic [COMP_W-1:0] red;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] blue;
    logic [CNT_W-1:0]  used_count;
    status_e           status;
  } res_t;

endpackage

[rtl/palette_compaction_engine_core.sv]
// Top level of the palette compaction engine: configuration register,
// stream ports, front end and back end. Depends on pce_pkg, pce_front, pce_back.
//
// Each transaction is decoded and queued by the front end (two entries) and
// executed by the back end in a read step, for the registered reads of the
// palette, used-mark and remap memories, and an execute step for the update
// and the result, so the back end takes a new item only after the last one
// has its result. A finish that compacts walks the palette one entry per
// cycle. After reset and after every start item the used-mark memory is
// cleared row by row; no item is taken during a clear. A result waits in an
// output register, and the next item executes as soon as it is taken.
// Write palette_size only while the block is idle; values above MAX_COLORS
// act as MAX_COLORS.
module palette_compaction_engine_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pce_pkg::CFG_W-1:0]     cfg_wdata_i,     // palette_size
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // color_index, red_in, green_in, blue_in, zero padding
  input  logic [pce_pkg::S_DATA_W-1:0]  s_axis_tdata_i,
  // kind
  input  logic [pce_pkg::KIND_W-1:0]    s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // new_index, red_out, green_out, blue_out, used_count, status, zero padding
  output logic [pce_pkg::M_DATA_W-1:0]  m_axis_tdata_o
);

  logic [pce_pkg::CFG_W-1:0]  palette_size_q;
  logic [pce_pkg::CNT_W-1:0]  eff_size;
  logic                       busy;
  logic                       pop;
  logic                       item_valid;
  pce_pkg::item_t             item;
  pce_pkg::res_t              res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      palette_size_q <= '0;
    end else if (cfg_we_i) begin
      palette_size_q <= cfg_wdata_i;
    end
  end

  assign eff_size = (32'(palette_size_q) > pce_pkg::MAX_COLORS) ?
                    pce_pkg::CNT_W'(pce_pkg::MAX_COLORS) :
                    pce_pkg::CNT_W'(palette_size_q);

  pce_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .eff_size_i      (eff_size),
    .busy_i          (busy),
    .pop_i           (pop),
    .item_valid_o    (item_valid),
    .item_o          (item)
  );

  pce_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .eff_size_i   (eff_size),
    .cfg_we_i     (cfg_we_i),
    .item_valid_i (item_valid),
    .item_i       (item),
    .pop_o        (pop),
    .busy_o       (busy),
    .res_valid_o  (m_axis_tvalid_o),
    .res_ready_i  (m_axis_tready_i),
    .res_o        (res)
  );

  assign m_axis_tdata_o = pce_pkg::M_DATA_W'({res.status, res.used_count, res.blue,
                                              res.green, res.red, res.new_index});

endmodule

[rtl/pce_front.sv]
// Front end: accepts input transactions, decodes the kind, checks the index
// range and holds decoded items in a two-entry queue. Depends on pce_pkg.
module pce_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [pce_pkg::S_DATA_W-1:0]  s_axis_tdata_i,
  input  logic [pce_pkg::KIND_W-1:0]    s_axis_tuser_i,
  input  logic [pce_pkg::CNT_W-1:0]     eff_size_i,
  input  logic                          busy_i,
  input  logic                          pop_i,
  output logic                          item_valid_o,
  output pce_pkg::item_t                item_o
);

  pce_pkg::item_t                item_d;
  pce_pkg::item_t                q_mem_q [pce_pkg::QDEPTH];
  logic [pce_pkg::QPTR_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [pce_pkg::QPTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [pce_pkg::QPTR_W:0]      cnt_q, cnt_d;
  logic                          push;

  always_comb begin
    item_d.idx   = s_axis_tdata_i[pce_pkg::IDX_W-1:0];
    item_d.red   = s_axis_tdata_i[pce_pkg::IDX_W +: pce_pkg::COMP_W];
    item_d.green = s_axis_tdata_i[pce_pkg::IDX_W + pce_pkg::COMP_W +: pce_pkg::COMP_W];
    item_d.blue  = s_axis_tdata_i[pce_pkg::IDX_W + 2 * pce_pkg::COMP_W +: pce_pkg::COMP_W];
    item_d.in_range = ({1'b0, item_d.idx} < eff_size_i);
    case (s_axis_tuser_i)
      pce_pkg::OP_WRITE:  item_d.op = pce_pkg::OP_WRITE;
      pce_pkg::OP_SCAN:   item_d.op = pce_pkg::OP_SCAN;
      pce_pkg::OP_FINISH: item_d.op = pce_pkg::OP_FINISH;
      pce_pkg::OP_REMAP:  item_d.op = pce_pkg::OP_REMAP;
      pce_pkg::OP_READ:   item_d.op = pce_pkg::OP_READ;
      pce_pkg::OP_START:  item_d.op = pce_pkg::OP_START;
      default:            item_d.op = pce_pkg::OP_NOP;
    endcase
  end

  assign s_axis_tready_o = (cnt_q != (pce_pkg::QPTR_W+1)'(pce_pkg::QDEPTH)) && !busy_i;
  assign push            = s_axis_tvalid_i && s_axis_tready_o;
  assign item_valid_o    = (cnt_q != '0);
  assign item_o          = q_mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push  ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= item_d;
    end
  end

endmodule

[rtl/pce_back.sv]
// Back end: executes decoded items against the palette, used-mark and remap
// memories, runs the compaction walk and the mark clear. Depends on pce_pkg.
module pce_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [pce_pkg::CNT_W-1:0]  eff_size_i,
  input  logic                       cfg_we_i,
  input  logic                       item_valid_i,
  input  pce_pkg::item_t             item_i,
  output logic                       pop_o,
  output logic                       busy_o,
  output logic                       res_valid_o,
  input  logic                       res_ready_i,
  output pce_pkg::res_t              res_o
);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_EXEC  = 4'b0100,
    S_WALK  = 4'b1000
  } state_e;

  state_e                          state_q, state_d;
  pce_pkg::item_t                  item_q;
  logic [pce_pkg::ROW_W-1:0]       clr_row_q, clr_row_d;
  logic [pce_pkg::CNT_W-1:0]       walk_idx_q, walk_idx_d;
  logic                            walk_vld_q, walk_vld_d;
  logic [pce_pkg::IDX_W-1:0]       walk_pos_q, walk_pos_d;
  logic [pce_pkg::CNT_W-1:0]       n_q, n_d;
  logic [pce_pkg::CNT_W-1:0]       distinct_q, distinct_d;
  logic                            packed_q, packed_d;
  logic                            compacted_q, compacted_d;
  logic                            out_valid_q, out_valid_d;
  pce_pkg::res_t                   out_q, res_d;
  logic                            out_load;
  logic [pce_pkg::CNT_W-1:0]       read_lim;

  logic [pce_pkg::RGB_W-1:0]       pal_mem [pce_pkg::MAX_COLORS];
  logic [pce_pkg::MARK_W-1:0]      mark_mem [pce_pkg::MARK_ROWS];
  logic [pce_pkg::IDX_W-1:0]       remap_mem [pce_pkg::MAX_COLORS];

  logic [pce_pkg::IDX_W-1:0]       rd_addr;
  logic [pce_pkg::RGB_W-1:0]       pal_rd_q;
  logic [pce_pkg::MARK_W-1:0]      mark_rd_q;
  logic [pce_pkg::IDX_W-1:0]       remap_rd_q;

  logic                            pal_we;
  logic [pce_pkg::IDX_W-1:0]       pal_waddr;
  logic [pce_pkg::RGB_W-1:0]       pal_wdata;
  logic                            mark_we;
  logic [pce_pkg::ROW_W-1:0]       mark_waddr;
  logic [pce_pkg::MARK_W-1:0]      mark_wdata;
  logic                            remap_we;
  logic [pce_pkg::IDX_W-1:0]       remap_waddr;
  logic [pce_pkg::IDX_W-1:0]       remap_wdata;
  logic                            mark_bit;
  logic                            walk_bit;

  assign pop_o       = (state_q == S_IDLE) && item_valid_i && (!out_valid_q || res_ready_i);
  assign busy_o      = (state_q == S_CLEAR);
  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;
  assign rd_addr     = (state_q == S_WALK) ? walk_idx_q[pce_pkg::IDX_W-1:0] : item_i.idx;
  assign mark_bit    = mark_rd_q[item_q.idx[pce_pkg::BIT_W-1:0]];
  assign walk_bit    = mark_rd_q[walk_pos_q[pce_pkg::BIT_W-1:0]];
  assign read_lim    = compacted_q ? distinct_q : eff_size_i;

  always_comb begin
    state_d     = state_q;
    clr_row_d   = clr_row_q;
    walk_idx_d  = walk_idx_q;
    walk_vld_d  = walk_vld_q;
    walk_pos_d  = walk_pos_q;
    n_d         = n_q;
    distinct_d  = distinct_q;
    packed_d    = packed_q;
    compacted_d = compacted_q;
    out_load    = 1'b0;
    pal_we      = 1'b0;
    pal_waddr   = item_q.idx;
    pal_wdata   = {item_q.red, item_q.green, item_q.blue};
    mark_we     = 1'b0;
    mark_waddr  = item_q.idx[pce_pkg::IDX_W-1:pce_pkg::BIT_W];
    mark_wdata  = mark_rd_q | (pce_pkg::MARK_W'(1) << item_q.idx[pce_pkg::BIT_W-1:0]);
    remap_we    = 1'b0;
    remap_waddr = walk_pos_q;
    remap_wdata = walk_bit ? n_q[pce_pkg::IDX_W-1:0] : '0;

    res_d            = '0;
    res_d.used_count = distinct_q;
    res_d.status     = pce_pkg::ST_OK;

    case (state_q)
      S_CLEAR: begin
        mark_we    = 1'b1;
        mark_waddr = clr_row_q;
        mark_wdata = '0;
        if (clr_row_q == pce_pkg::ROW_W'(pce_pkg::MARK_ROWS - 1)) begin
          state_d = S_IDLE;
        end else begin
          clr_row_d = clr_row_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (pop_o) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        out_load = 1'b1;
        state_d  = S_IDLE;
        case (item_q.op)
          pce_pkg::OP_WRITE: begin
            if (item_q.in_range) begin
              pal_we   = 1'b1;
              packed_d = 1'b0;
            end else begin
              res_d.status = pce_pkg::ST_RANGE;
            end
          end
          pce_pkg::OP_SCAN: begin
            if (item_q.in_range) begin
              if (!mark_bit) begin
                mark_we    = 1'b1;
                distinct_d = distinct_q + 1'b1;
              end
              res_d.used_count = distinct_d;
            end else begin
              res_d.status = pce_pkg::ST_RANGE;
            end
          end
          pce_pkg::OP_FINISH: begin
            if ((eff_size_i <= pce_pkg::CNT_W'(2)) || packed_q) begin
              compacted_d      = 1'b0;
              res_d.used_count = eff_size_i;
              res_d.status     = pce_pkg::ST_SKIP;
            end else if (distinct_q >= eff_size_i) begin
              packed_d         = 1'b1;
              compacted_d      = 1'b0;
              res_d.used_count = eff_size_i;
              res_d.status     = pce_pkg::ST_FULL;
            end else begin
              out_load   = 1'b0;
              state_d    = S_WALK;
              walk_idx_d = '0;
              walk_vld_d = 1'b0;
              n_d        = '0;
            end
          end
          pce_pkg::OP_REMAP: begin
            if (item_q.in_range) begin
              res_d.new_index = compacted_q ? remap_rd_q : item_q.idx;
            end else begin
              res_d.status = pce_pkg::ST_RANGE;
            end
          end
          pce_pkg::OP_READ: begin
            if ({1'b0, item_q.idx} < read_lim) begin
              {res_d.red, res_d.green, res_d.blue} = pal_rd_q;
            end else begin
              res_d.status = pce_pkg::ST_RANGE;
            end
          end
          pce_pkg::OP_START: begin
            distinct_d       = '0;
            compacted_d      = 1'b0;
            res_d.used_count = '0;
            state_d          = S_CLEAR;
            clr_row_d        = '0;
          end
          default: begin
            res_d.used_count = '0;
          end
        endcase
      end
      S_WALK: begin
        if (walk_vld_q) begin
          remap_we = 1'b1;
          if (walk_bit) begin
            pal_we    = 1'b1;
            pal_waddr = n_q[pce_pkg::IDX_W-1:0];
            pal_wdata = pal_rd_q;
            n_d       = n_q + 1'b1;
          end
        end
        if (walk_idx_q < eff_size_i) begin
          walk_vld_d = 1'b1;
          walk_pos_d = walk_idx_q[pce_pkg::IDX_W-1:0];
          walk_idx_d = walk_idx_q + 1'b1;
        end else begin
          walk_vld_d = 1'b0;
          if (!walk_vld_q) begin
            distinct_d       = n_q;
            packed_d         = 1'b1;
            compacted_d      = 1'b1;
            res_d.used_count = n_q;
            out_load         = 1'b1;
            state_d          = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (cfg_we_i) begin
      packed_d = 1'b0;
    end

    if (out_load) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && !res_ready_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_row_q   <= '0;
      walk_idx_q  <= '0;
      walk_vld_q  <= 1'b0;
      n_q         <= '0;
      distinct_q  <= '0;
      packed_q    <= 1'b0;
      compacted_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_row_q   <= clr_row_d;
      walk_idx_q  <= walk_idx_d;
      walk_vld_q  <= walk_vld_d;
      n_q         <= n_d;
      distinct_q  <= distinct_d;
      packed_q    <= packed_d;
      compacted_q <= compacted_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    walk_pos_q <= walk_pos_d;
    if (pop_o) begin
      item_q <= item_i;
    end
    if (out_load) begin
      out_q <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pal_we) begin
      pal_mem[pal_waddr] <= pal_wdata;
    end
    pal_rd_q <= pal_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (mark_we) begin
      mark_mem[mark_waddr] <= mark_wdata;
    end
    mark_rd_q <= mark_mem[rd_addr[pce_pkg::IDX_W-1:pce_pkg::BIT_W]];
  end

  always_ff @(posedge clk_i) begin
    if (remap_we) begin
      remap_mem[remap_waddr] <= remap_wdata;
    end
    remap_rd_q <= remap_mem[rd_addr];
  end

  a_out_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || res_ready_i))
    else $error("result register loaded while a result is pending");

  a_walk_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    walk_vld_q |-> (n_q <= {1'b0, walk_pos_q}))
    else $error("compaction write index passed read index");

  a_distinct_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    distinct_q <= pce_pkg::CNT_W'(pce_pkg::MAX_COLORS))
    else $error("distinct count above palette capacity");

  a_start_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC && item_q.op == pce_pkg::OP_START) |=>
      (state_q == S_CLEAR && clr_row_q == '0))
    else $error("start did not launch a mark clear");

endmodule

[sim/tb.sv]
// Self-checking testbench for palette_compaction_engine_core. Depends on pce_pkg.
// Drives directed and random transactions with random idling on both stream sides and
// checks every result against a palette compaction predictor or a directed reply.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int unsigned CLEAR_PAUSE = pce_pkg::MAX_COLORS / pce_pkg::MARK_W + 8;
  localparam int unsigned TAIL_CYCLES = 16;
  localparam int unsigned ITEM_GOAL   = 1850;
  localparam logic [pce_pkg::KIND_W-1:0] KIND_UNDEF = 3'd7;

  localparam int O_RED   = pce_pkg::IDX_W;
  localparam int O_GREEN = O_RED + pce_pkg::COMP_W;
  localparam int O_BLUE  = O_GREEN + pce_pkg::COMP_W;
  localparam int O_CNT   = O_BLUE + pce_pkg::COMP_W;
  localparam int O_ST    = O_CNT + pce_pkg::CNT_W;

  logic                         clk_i           = 1'b0;
  logic                         rst_ni          = 1'b0;
  logic                         cfg_we_i        = 1'b0;
  logic [pce_pkg::CFG_W-1:0]    cfg_wdata_i     = '0;
  logic                         s_axis_tvalid_i = 1'b0;
  logic                         s_axis_tready_o;
  logic [pce_pkg::S_DATA_W-1:0] s_axis_tdata_i  = '0;
  logic [pce_pkg::KIND_W-1:0]   s_axis_tuser_i  = '0;
  logic                         m_axis_tvalid_o;
  logic                         m_axis_tready_i = 1'b1;
  logic [pce_pkg::M_DATA_W-1:0] m_axis_tdata_o;

  palette_compaction_engine_core u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // predictor state
  bit [pce_pkg::RGB_W-1:0] pal_mem   [pce_pkg::MAX_COLORS];
  bit                      pal_known [pce_pkg::MAX_COLORS];
  bit                      mark_mem  [pce_pkg::MAX_COLORS];
  bit [pce_pkg::IDX_W-1:0] map_mem   [pce_pkg::MAX_COLORS];
  bit                      map_known [pce_pkg::MAX_COLORS];
  int unsigned    distinct_n  = 0;
  bit             packed_q    = 1'b0;
  bit             compacted_q = 1'b0;
  int unsigned    size_reg    = 0;

  pce_pkg::res_t palette_replies[$];
  int unsigned mismatches   = 0;
  int unsigned items_sent   = 0;
  int unsigned settings_cnt = 0;
  int unsigned compactions  = 0;
  int unsigned cycles       = 0;
  int unsigned ready_hold   = 0;
  bit          calm         = 1'b0;
  pce_pkg::res_t got;
  pce_pkg::res_t want;

  typedef struct {
    bit                         is_cfg;
    logic [pce_pkg::CFG_W-1:0]  cfg;
    logic [pce_pkg::KIND_W-1:0] kind;
    logic [pce_pkg::IDX_W-1:0]  idx;
    logic [pce_pkg::COMP_W-1:0] r;
    logic [pce_pkg::COMP_W-1:0] g;
    logic [pce_pkg::COMP_W-1:0] b;
    bit                         typed;
    pce_pkg::res_t              exp;
  } row_t;

  row_t directed_rows[$];

  function automatic int unsigned palette_limit();
    return (size_reg > pce_pkg::MAX_COLORS) ? pce_pkg::MAX_COLORS : size_reg;
  endfunction

  function automatic pce_pkg::res_t compute_palette_reply(
      logic [pce_pkg::KIND_W-1:0] kind, logic [pce_pkg::IDX_W-1:0] idx,
      logic [pce_pkg::COMP_W-1:0] r, logic [pce_pkg::COMP_W-1:0] g,
      logic [pce_pkg::COMP_W-1:0] b);
    pce_pkg::res_t o;
    int unsigned sz;
    int unsigned lim;
    int unsigned n;
    int unsigned i;
    sz = palette_limit();
    o = '0;
    o.used_count = pce_pkg::CNT_W'(distinct_n);
    o.status = pce_pkg::ST_OK;
    case (kind)
      pce_pkg::OP_WRITE: begin
        if (idx < sz) begin
          pal_mem[idx] = {r, g, b};
          pal_known[idx] = 1'b1;
          packed_q = 1'b0;
        end else begin
          o.status = pce_pkg::ST_RANGE;
        end
      end
      pce_pkg::OP_SCAN: begin
        if (idx < sz) begin
          if (!mark_mem[idx]) begin
            mark_mem[idx] = 1'b1;
            distinct_n = (distinct_n + 1) & 32'h1FFF;
          end
          o.used_count = pce_pkg::CNT_W'(distinct_n);
        end else begin
          o.status = pce_pkg::ST_RANGE;
        end
      end
      pce_pkg::OP_FINISH: begin
        if (sz <= 2 || packed_q) begin
          compacted_q = 1'b0;
          o.used_count = pce_pkg::CNT_W'(sz);
          o.status = pce_pkg::ST_SKIP;
        end else if (distinct_n >= sz) begin
          packed_q = 1'b1;
          compacted_q = 1'b0;
          o.used_count = pce_pkg::CNT_W'(sz);
          o.status = pce_pkg::ST_FULL;
        end else begin
          n = 0;
          for (i = 0; i < sz; i++) begin
            if (mark_mem[i]) begin
              pal_mem[n] = pal_mem[i];
              pal_known[n] = pal_known[i];
              map_mem[i] = pce_pkg::IDX_W'(n);
              n++;
            end else begin
              map_mem[i] = '0;
            end
            map_known[i] = 1'b1;
          end
          distinct_n = n;
          packed_q = 1'b1;
          compacted_q = 1'b1;
          o.used_count = pce_pkg::CNT_W'(n);
          compactions++;
        end
      end
      pce_pkg::OP_REMAP: begin
        if (idx < sz) begin
          o.new_index = compacted_q ? map_mem[idx] : idx;
        end else begin
          o.status = pce_pkg::ST_RANGE;
        end
      end
      pce_pkg::OP_READ: begin
        lim = compacted_q ? distinct_n : sz;
        if (lim > pce_pkg::MAX_COLORS) lim = pce_pkg::MAX_COLORS;
        if (idx < lim) begin
          {o.red, o.green, o.blue} = pal_mem[idx];
        end else begin
          o.status = pce_pkg::ST_RANGE;
        end
      end
      pce_pkg::OP_START: begin
        for (i = 0; i < pce_pkg::MAX_COLORS; i++) mark_mem[i] = 1'b0;
        distinct_n = 0;
        compacted_q = 1'b0;
        o.used_count = '0;
      end
      default: begin
        o.used_count = '0;
      end
    endcase
    return o;
  endfunction

  // reads of entries never written are not part of the contract
  function automatic bit touches_unwritten(logic [pce_pkg::KIND_W-1:0] kind,
                                           logic [pce_pkg::IDX_W-1:0] idx);
    int unsigned lim;
    if (kind == pce_pkg::OP_READ) begin
      lim = compacted_q ? distinct_n : palette_limit();
      if (lim > pce_pkg::MAX_COLORS) lim = pce_pkg::MAX_COLORS;
      return (idx < lim) && !pal_known[idx];
    end
    if (kind == pce_pkg::OP_REMAP)
      return compacted_q && (idx < palette_limit()) && !map_known[idx];
    return 1'b0;
  endfunction

  function automatic pce_pkg::res_t reply(int ni, int r, int g, int b, int cnt,
                                          pce_pkg::status_e st);
    pce_pkg::res_t o;
    o.new_index  = pce_pkg::IDX_W'(ni);
    o.red        = pce_pkg::COMP_W'(r);
    o.green      = pce_pkg::COMP_W'(g);
    o.blue       = pce_pkg::COMP_W'(b);
    o.used_count = pce_pkg::CNT_W'(cnt);
    o.status     = st;
    return o;
  endfunction

  task automatic check_field(string name, int unsigned e, int unsigned a);
    if (e != a) begin
      $error("%s: expected %0d, actual %0d", name, e, a);
      mismatches++;
    end
  endtask

  task automatic drain_replies();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (palette_replies.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_palette_size(logic [pce_pkg::CFG_W-1:0] value);
    drain_replies();
    repeat (CLEAR_PAUSE) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    size_reg = value;
    packed_q = 1'b0;
    settings_cnt++;
  endtask

  task automatic deliver(logic [pce_pkg::KIND_W-1:0] kind_in, logic [pce_pkg::IDX_W-1:0] idx,
                         logic [pce_pkg::COMP_W-1:0] r, logic [pce_pkg::COMP_W-1:0] g,
                         logic [pce_pkg::COMP_W-1:0] b, bit typed,
                         pce_pkg::res_t typed_res);
    logic [pce_pkg::KIND_W-1:0] kind;
    int unsigned                gap;
    pce_pkg::res_t              pred;
    kind = kind_in;
    if (touches_unwritten(kind, idx)) kind = pce_pkg::OP_SCAN;
    // hold until every pending result is back
    if (items_sent % 500 == 250 || $urandom_range(0, 99) == 0) drain_replies();
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= kind;
    s_axis_tdata_i <= {{(pce_pkg::S_DATA_W - pce_pkg::S_FIELDS_W){1'b0}}, b, g, r, idx};
    do @(posedge clk_i); while (!s_axis_tready_o);
    pred = compute_palette_reply(kind, idx, r, g, b);
    palette_replies.push_back(typed ? typed_res : pred);
    if (kind < pce_pkg::OP_NOP) items_sent++;
  endtask

  task automatic issue(logic [pce_pkg::KIND_W-1:0] kind, logic [pce_pkg::IDX_W-1:0] idx);
    if ($urandom_range(0, 9) == 0)
      deliver(pce_pkg::KIND_W'($urandom_range(0, 7)),
              pce_pkg::IDX_W'($urandom_range(0, 4095)),
              pce_pkg::COMP_W'($urandom_range(0, 255)),
              pce_pkg::COMP_W'($urandom_range(0, 255)),
              pce_pkg::COMP_W'($urandom_range(0, 255)), 1'b0, '0);
    deliver(kind, idx, pce_pkg::COMP_W'($urandom_range(0, 255)),
            pce_pkg::COMP_W'($urandom_range(0, 255)),
            pce_pkg::COMP_W'($urandom_range(0, 255)), 1'b0, '0);
  endtask

  function automatic logic [pce_pkg::IDX_W-1:0] pick_index(int unsigned ez);
    if (ez == 0 || $urandom_range(0, 7) == 0) return pce_pkg::IDX_W'($urandom_range(0, 4095));
    return pce_pkg::IDX_W'($urandom_range(0, ez - 1));
  endfunction

  task automatic run_session();
    int unsigned pick;
    int unsigned sz;
    int unsigned ez;
    int unsigned i;
    int unsigned n;
    pick = $urandom_range(0, 99);
    if (pick < 8) sz = $urandom_range(0, 2);
    else if (pick < 78) sz = $urandom_range(3, 24);
    else if (pick < 94) sz = $urandom_range(25, 300);
    else if (pick < 97) sz = $urandom_range(4095, 4096);
    else sz = $urandom_range(4097, 8191);
    set_palette_size(pce_pkg::CFG_W'(sz));
    calm = ($urandom_range(0, 3) == 0);
    ez = (sz > pce_pkg::MAX_COLORS) ? pce_pkg::MAX_COLORS : sz;
    if (ez <= 48) begin
      for (i = 0; i < ez; i++) issue(pce_pkg::OP_WRITE, pce_pkg::IDX_W'(i));
    end else begin
      for (i = 0; i < 24; i++) issue(pce_pkg::OP_WRITE, pick_index(ez));
    end
    if ($urandom_range(0, 7) != 0)
      issue(pce_pkg::OP_START, pce_pkg::IDX_W'($urandom_range(0, 4095)));
    if (ez > 0 && ez <= 48 && $urandom_range(0, 4) == 0) begin
      for (i = 0; i < ez; i++) issue(pce_pkg::OP_SCAN, pce_pkg::IDX_W'(i));
    end
    n = $urandom_range(1, 20);
    for (i = 0; i < n; i++) issue(pce_pkg::OP_SCAN, pick_index(ez));
    issue(pce_pkg::OP_FINISH, pce_pkg::IDX_W'($urandom_range(0, 4095)));
    if ($urandom_range(0, 3) == 0)
      issue(pce_pkg::OP_FINISH, pce_pkg::IDX_W'($urandom_range(0, 4095)));
    if ($urandom_range(0, 5) == 0) begin
      issue(pce_pkg::OP_WRITE, pick_index(ez));
      issue(pce_pkg::OP_FINISH, pce_pkg::IDX_W'($urandom_range(0, 4095)));
    end
    n = $urandom_range(1, 16);
    for (i = 0; i < n; i++) issue(pce_pkg::OP_REMAP, pick_index(ez));
    n = $urandom_range(1, 12);
    for (i = 0; i < n; i++) issue(pce_pkg::OP_READ, pick_index(ez));
  endtask

  task automatic add_row(bit is_cfg, logic [pce_pkg::CFG_W-1:0] cfg,
                         logic [pce_pkg::KIND_W-1:0] kind, logic [pce_pkg::IDX_W-1:0] idx,
                         logic [pce_pkg::COMP_W-1:0] r, logic [pce_pkg::COMP_W-1:0] g,
                         logic [pce_pkg::COMP_W-1:0] b, bit typed, pce_pkg::res_t exp);
    row_t row;
    row.is_cfg = is_cfg;
    row.cfg    = cfg;
    row.kind   = kind;
    row.idx    = idx;
    row.r      = r;
    row.g      = g;
    row.b      = b;
    row.typed  = typed;
    row.exp    = exp;
    directed_rows.push_back(row);
  endtask

  always @(posedge clk_i) begin
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      got.new_index  = m_axis_tdata_o[pce_pkg::IDX_W-1:0];
      got.red        = m_axis_tdata_o[O_RED +: pce_pkg::COMP_W];
      got.green      = m_axis_tdata_o[O_GREEN +: pce_pkg::COMP_W];
      got.blue       = m_axis_tdata_o[O_BLUE +: pce_pkg::COMP_W];
      got.used_count = m_axis_tdata_o[O_CNT +: pce_pkg::CNT_W];
      got.status     = pce_pkg::status_e'(m_axis_tdata_o[O_ST +: pce_pkg::STATUS_W]);
      if (palette_replies.size() == 0) begin
        $error("result transaction with nothing pending");
        mismatches++;
      end else begin
        want = palette_replies.pop_front();
        check_field("new_index", want.new_index, got.new_index);
        check_field("red_out", want.red, got.red);
        check_field("green_out", want.green, got.green);
        check_field("blue_out", want.blue, got.blue);
        check_field("used_count", want.used_count, got.used_count);
        check_field("status", want.status, got.status);
      end
      ready_hold = calm ? 0 : $urandom_range(0, 5);
      m_axis_tready_i <= (ready_hold == 0);
    end else if (ready_hold != 0) begin
      ready_hold--;
      m_axis_tready_i <= (ready_hold == 0);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  initial begin
    add_row(0, '0, pce_pkg::OP_REMAP, 12'd0, 8'h00, 8'h00, 8'h00, 1,
            reply(0, 0, 0, 0, 0, pce_pkg::ST_RANGE));
    add_row(0, '0, pce_pkg::OP_WRITE, 12'd4095, 8'hff, 8'hff, 8'hff, 1,
            reply(0, 0, 0, 0, 0, pce_pkg::ST_RANGE));
    add_row(0, '0, pce_pkg::OP_FINISH, 12'd0, 8'h00, 8'h00, 8'h00, 1,
            reply(0, 0, 0, 0, 0, pce_pkg::ST_SKIP));
    add_row(0, '0, pce_pkg::OP_NOP, 12'd4095, 8'hff, 8'hff, 8'hff, 1,
            reply(0, 0, 0, 0, 0, pce_pkg::ST_OK));
    add_row(0, '0, KIND_UNDEF, 12'd0, 8'h00, 8'h00, 8'h00, 1,
            reply(0, 0, 0, 0, 0, pce_pkg::ST_OK));
    add_row(1, 13'd8191, pce_pkg::OP_NOP, '0, '0, '0, '0, 0, '0);
    add_row(0, '0, pce_pkg::OP_WRITE, 12'd4095, 8'hff, 8'hff, 8'hff, 1,
            reply(0, 0, 0, 0, 0, pce_pkg::ST_OK));
    add_row(0, '0, pce_pkg::OP_WRITE, 12'd0, 8'h00, 8'h00, 8'h00, 1,
            reply(0, 0, 0, 0, 0, pce_pkg::ST_OK));
    add_row(0, '0, pce_pkg::OP_READ, 12'd4095, 8'h00, 8'h00, 8'h00, 1,
            reply(0, 255, 255, 255, 0, pce_pkg::ST_OK));
    add_row(0, '0, pce_pkg::OP_SCAN, 12'd4095, 8'h00, 8'h00, 8'h00, 1,
            reply(0, 0, 0, 0, 1, pce_pkg::ST_OK));
    add_row(0, '0, pce_pkg::OP_REMAP, 12'd4095, 8'h00, 8'h00, 8'h00, 1,
            reply(4095, 0, 0, 0, 1, pce_pkg::ST_OK));
    add_row(1, 13'd4, pce_pkg::OP_NOP, '0, '0, '0, '0, 0, '0);
    add_row(0, '0, pce_pkg::OP_WRITE, 12'd1, 8'h12, 8'h34, 8'h56, 0, '0);
    add_row(0, '0, pce_pkg::OP_WRITE, 12'd2, 8'h9a, 8'hbc, 8'hde, 0, '0);
    add_row(0, '0, pce_pkg::OP_WRITE, 12'd3, 8'h5a, 8'ha5, 8'hc3, 0, '0);
    add_row(0, '0, pce_pkg::OP_START, 12'd0, 8'h00, 8'h00, 8'h00, 1,
            reply(0, 0, 0, 0, 0, pce_pkg::ST_OK));
    add_row(0, '0, pce_pkg::OP_SCAN, 12'd1, 8'h00, 8'h00, 8'h00, 0, '0);
    add_row(0, '0, pce_pkg::OP_SCAN, 12'd3, 8'h00, 8'h00, 8'h00, 0, '0);
    add_row(0, '0, pce_pkg::OP_SCAN, 12'd5, 8'h00, 8'h00, 8'h00, 0, '0);
    add_row(0, '0, pce_pkg::OP_FINISH, 12'd0, 8'h00, 8'h00, 8'h00, 0, '0);
    add_row(0, '0, pce_pkg::OP_REMAP, 12'd3, 8'h00, 8'h00, 8'h00, 0, '0);
    add_row(0, '0, pce_pkg::OP_REMAP, 12'd0, 8'h00, 8'h00, 8'h00, 0, '0);
    add_row(0, '0, pce_pkg::OP_READ, 12'd1, 8'h00, 8'h00, 8'h00, 0, '0);
    add_row(0, '0, pce_pkg::OP_READ, 12'd2, 8'h00, 8'h00, 8'h00, 1,
            reply(0, 0, 0, 0, 2, pce_pkg::ST_RANGE));
    add_row(0, '0, pce_pkg::OP_FINISH, 12'd0, 8'h00, 8'h00, 8'h00, 1,
            reply(0, 0, 0, 0, 4, pce_pkg::ST_SKIP));
    add_row(1, 13'd3, pce_pkg::OP_NOP, '0, '0, '0, '0, 0, '0);
    add_row(0, '0, pce_pkg::OP_START, 12'd0, 8'h00, 8'h00, 8'h00, 1,
            reply(0, 0, 0, 0, 0, pce_pkg::ST_OK));
    add_row(0, '0, pce_pkg::OP_SCAN, 12'd0, 8'h00, 8'h00, 8'h00, 0, '0);
    add_row(0, '0, pce_pkg::OP_SCAN, 12'd1, 8'h00, 8'h00, 8'h00, 0, '0);
    add_row(0, '0, pce_pkg::OP_SCAN, 12'd2, 8'h00, 8'h00, 8'h00, 0, '0);
    add_row(0, '0, pce_pkg::OP_FINISH, 12'd0, 8'h00, 8'h00, 8'h00, 1,
            reply(0, 0, 0, 0, 3, pce_pkg::ST_FULL));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[k]) begin
      if (directed_rows[k].is_cfg)
        set_palette_size(directed_rows[k].cfg);
      else
        deliver(directed_rows[k].kind, directed_rows[k].idx, directed_rows[k].r,
                directed_rows[k].g, directed_rows[k].b, directed_rows[k].typed,
                directed_rows[k].exp);
    end

    while (items_sent < ITEM_GOAL) run_session();

    drain_replies();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("run covered %0d transactions over %0d palette_size settings", items_sent,
             settings_cnt);
    $display("%0d compacting finishes, %0d mismatches", compactions, mismatches);
    if (mismatches == 0 && palette_replies.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
